[hw/rtl/assert_macros.svh]
// Assertion macros shared by the receive parser RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FPR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

`define FPR_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`else

`define FPR_ASSERT(label, prop)

`define FPR_ASSERT_NEVER(label, cond)

`endif

`endif

[hw/rtl/fpr_pkg.sv]
// Package for the framed packet receive parser: framing bytes, event codes
// and the byte-wide CRC-16 update. It depends on nothing else.
package fpr_pkg;

  localparam int MaxLengthDefault = 1026;

  localparam logic [7:0] ByteStx = 8'h02;
  localparam logic [7:0] ByteEtx = 8'h03;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvPayload = 3'd1,
    EvDone    = 3'd2,
    EvBadLen  = 3'd3,
    EvBadEtx  = 3'd4,
    EvBadCrc  = 3'd5
  } rx_event_e;

  // One byte of the reflected CRC-16 with polynomial 0x8408.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  x;
    logic [3:0]  lo;
    logic [15:0] r;
    x  = crc[7:0] ^ b;
    lo = x[3:0];
    r  = {8'h00, crc[15:8]} ^ {x, 8'h00} ^ {5'b0, x, 3'b0} ^ {lo, 12'h000}
       ^ {12'h000, x[7:4]} ^ {12'h000, lo} ^ {5'b0, lo, 7'b0};
    return r;
  endfunction

endpackage

[hw/rtl/framed_packet_rx_parser.sv]
// Framed packet receive parser: one received byte per item, one result per item.
// The result is registered in the cycle after its byte is accepted; one item is
// accepted every cycle while the output side drains the single result register.
// Reset clears the parse state, all frame fields, the CRC and the CRC enforce
// bit, and leaves the result register empty.
// Depends on fpr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module framed_packet_rx_parser #(
  parameter int MaxLength = fpr_pkg::MaxLengthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  payload_byte_o,
  output logic [9:0]  payload_index_o,
  output logic [15:0] frame_version_o,
  output logic [7:0]  transaction_id_o,
  output logic [7:0]  frame_kind_o,
  output logic [15:0] command_code_o,
  output logic [10:0] payload_length_o,
  output logic        crc_ok_o,
  output logic [15:0] computed_crc_o
);

  localparam int CntW = $clog2(MaxLength);

  typedef enum logic [3:0] {
    StHunt    = 4'd0,
    StVerLo   = 4'd1,
    StVerHi   = 4'd2,
    StLenLo   = 4'd3,
    StLenHi   = 4'd4,
    StTid     = 4'd5,
    StKind    = 4'd6,
    StCmdLo   = 4'd7,
    StCmdHi   = 4'd8,
    StPayload = 4'd9,
    StCrcLo   = 4'd10,
    StCrcHi   = 4'd11,
    StEtx     = 4'd12
  } state_e;

  state_e              state_q, state_d;
  logic [15:0]         version_q, version_d;
  logic [15:0]         length_q, length_d;
  logic [7:0]          tid_q, tid_d;
  logic [7:0]          kind_q, kind_d;
  logic [15:0]         command_q, command_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [15:0]         crc_q, crc_d;
  logic [15:0]         rx_crc_q, rx_crc_d;
  logic                enforce_q;
  logic                out_valid_q;
  fpr_pkg::rx_event_e  event_q, event_d;
  logic [7:0]          pbyte_q, pbyte_d;
  logic [9:0]          pidx_q, pidx_d;

  logic                in_fire;
  logic                cfg_fire;
  logic [15:0]         len_raw;
  logic                len_ok;
  logic [CntW-1:0]     cnt_nxt;
  logic [15:0]         crc_upd;
  logic [15:0]         rx_crc_full;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = ~out_valid_q | out_ready_i;
  assign in_fire     = in_valid_i & in_ready_o;

  assign len_raw     = {rx_byte_i, length_q[7:0]};
  assign len_ok      = (len_raw >= 16'd2) && ({1'b0, len_raw} <= 17'(MaxLength));
  assign cnt_nxt     = cnt_q + CntW'(1);
  assign crc_upd     = fpr_pkg::crc_byte(crc_q, rx_byte_i);
  assign rx_crc_full = {rx_byte_i, rx_crc_q[7:0]};

  always_comb begin
    state_d   = state_q;
    version_d = version_q;
    length_d  = length_q;
    tid_d     = tid_q;
    kind_d    = kind_q;
    command_d = command_q;
    cnt_d     = cnt_q;
    crc_d     = crc_q;
    rx_crc_d  = rx_crc_q;
    event_d   = fpr_pkg::EvNone;
    pbyte_d   = 8'h00;
    pidx_d    = 10'd0;
    case (state_q)
      StHunt: begin
        if (rx_byte_i == fpr_pkg::ByteStx) begin
          state_d = StVerLo;
        end
      end
      StVerLo: begin
        version_d = {8'h00, rx_byte_i};
        state_d   = StVerHi;
      end
      StVerHi: begin
        version_d = {rx_byte_i, version_q[7:0]};
        crc_d     = 16'h0000;
        state_d   = StLenLo;
      end
      StLenLo: begin
        length_d = {8'h00, rx_byte_i};
        crc_d    = crc_upd;
        state_d  = StLenHi;
      end
      StLenHi: begin
        if (len_ok) begin
          length_d = len_raw - 16'd2;
          crc_d    = crc_upd;
          state_d  = StTid;
        end else begin
          length_d = len_raw;
          event_d  = fpr_pkg::EvBadLen;
          state_d  = StHunt;
        end
      end
      StTid: begin
        tid_d   = rx_byte_i;
        state_d = StKind;
      end
      StKind: begin
        kind_d  = rx_byte_i;
        crc_d   = crc_upd;
        state_d = StCmdLo;
      end
      StCmdLo: begin
        command_d = {8'h00, rx_byte_i};
        crc_d     = crc_upd;
        state_d   = StCmdHi;
      end
      StCmdHi: begin
        command_d = {rx_byte_i, command_q[7:0]};
        crc_d     = crc_upd;
        cnt_d     = '0;
        state_d   = (length_q != 16'd0) ? StPayload : StCrcLo;
      end
      StPayload: begin
        event_d = fpr_pkg::EvPayload;
        pbyte_d = rx_byte_i;
        pidx_d  = 10'(cnt_q);
        crc_d   = crc_upd;
        cnt_d   = cnt_nxt;
        if (16'(cnt_nxt) >= length_q) begin
          state_d = StCrcLo;
        end
      end
      StCrcLo: begin
        rx_crc_d = {8'h00, rx_byte_i};
        state_d  = StCrcHi;
      end
      StCrcHi: begin
        rx_crc_d = rx_crc_full;
        if (enforce_q && (rx_crc_full != crc_q)) begin
          event_d = fpr_pkg::EvBadCrc;
          state_d = StHunt;
        end else begin
          state_d = StEtx;
        end
      end
      StEtx: begin
        event_d = (rx_byte_i == fpr_pkg::ByteEtx) ? fpr_pkg::EvDone : fpr_pkg::EvBadEtx;
        state_d = StHunt;
      end
      default: begin
        state_d = StHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StHunt;
      version_q   <= '0;
      length_q    <= '0;
      tid_q       <= '0;
      kind_q      <= '0;
      command_q   <= '0;
      cnt_q       <= '0;
      crc_q       <= '0;
      rx_crc_q    <= '0;
      enforce_q   <= 1'b0;
      out_valid_q <= 1'b0;
      event_q     <= fpr_pkg::EvNone;
      pbyte_q     <= '0;
      pidx_q      <= '0;
    end else begin
      if (cfg_fire) begin
        enforce_q <= cfg_data_i;
      end
      if (in_fire) begin
        state_q   <= state_d;
        version_q <= version_d;
        length_q  <= length_d;
        tid_q     <= tid_d;
        kind_q    <= kind_d;
        command_q <= command_d;
        cnt_q     <= cnt_d;
        crc_q     <= crc_d;
        rx_crc_q  <= rx_crc_d;
        event_q   <= event_d;
        pbyte_q   <= pbyte_d;
        pidx_q    <= pidx_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The frame fields are only updated together with the result register, so
  // the held state always matches the result on offer.
  assign out_valid_o      = out_valid_q;
  assign event_res_o      = event_q;
  assign payload_byte_o   = pbyte_q;
  assign payload_index_o  = pidx_q;
  assign frame_version_o  = version_q;
  assign transaction_id_o = tid_q;
  assign frame_kind_o     = kind_q;
  assign command_code_o   = command_q;
  assign payload_length_o = length_q[10:0];
  assign crc_ok_o         = (rx_crc_q == crc_q);
  assign computed_crc_o   = crc_q;

  `FPR_ASSERT(a_payload_event,
              (in_fire && state_q == StPayload) |=>
              (out_valid_q && event_q == fpr_pkg::EvPayload))
  `FPR_ASSERT(a_end_hunts, (out_valid_q && event_q >= fpr_pkg::EvDone) |-> (state_q == StHunt))
  `FPR_ASSERT(a_crc_cleared, (in_fire && state_q == StVerHi) |=> (crc_q == 16'h0000))
  `FPR_ASSERT(a_hunt_stays,
              (in_fire && state_q == StHunt && rx_byte_i != fpr_pkg::ByteStx) |=>
              (state_q == StHunt))
  `FPR_ASSERT_NEVER(a_count_bound, state_q == StPayload && 16'(cnt_q) >= length_q)

endmodule

[sim/tb_top.sv]
// Self-checking bench for framed_packet_rx_parser: a directed byte table, then framed traffic
// with random content, checked result by result against an in-bench parse model.
// Depends on fpr_pkg and the parser RTL only.
module tb_top;

  localparam int MaxLen = fpr_pkg::MaxLengthDefault;
  localparam int PhaseItems = 230;
  localparam int LongHold = 60;
  localparam int CycleLimit = 400000;
  localparam logic [7:0] KindCmd = 8'h43;
  localparam logic [7:0] KindStatus = 8'h53;

  typedef enum logic [3:0] {
    PsHunt = 4'd0, PsVerLo = 4'd1, PsVerHi = 4'd2, PsLenLo = 4'd3, PsLenHi = 4'd4,
    PsTid = 4'd5, PsKind = 4'd6, PsCmdLo = 4'd7, PsCmdHi = 4'd8, PsPayload = 4'd9,
    PsCrcLo = 4'd10, PsCrcHi = 4'd11, PsEtx = 4'd12
  } parse_st_e;

  typedef struct packed {
    fpr_pkg::rx_event_e ev;
    logic [7:0]         pbyte;
    logic [9:0]         pidx;
    logic [15:0]        ver;
    logic [7:0]         tid;
    logic [7:0]         kind;
    logic [15:0]        cmd;
    logic [10:0]        plen;
    logic               crc_ok;
    logic [15:0]        crc;
  } parse_res_t;

  typedef struct packed {
    logic [7:0]         b;
    logic               typed;
    fpr_pkg::rx_event_e ev;
  } dir_row_t;

  typedef struct packed {
    logic               typed;
    fpr_pkg::rx_event_e ev;
  } typed_ev_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  event_res_o;
  logic [7:0]  payload_byte_o;
  logic [9:0]  payload_index_o;
  logic [15:0] frame_version_o;
  logic [7:0]  transaction_id_o;
  logic [7:0]  frame_kind_o;
  logic [15:0] command_code_o;
  logic [10:0] payload_length_o;
  logic        crc_ok_o;
  logic [15:0] computed_crc_o;

  // Model state of the parser.
  parse_st_e   ps = PsHunt;
  logic        enforce_m = 1'b0;
  logic [15:0] ver_m = '0;
  logic [15:0] len_m = '0;
  logic [7:0]  tid_m = '0;
  logic [7:0]  kind_m = '0;
  logic [15:0] cmd_m = '0;
  logic [15:0] cnt_m = '0;
  logic [15:0] crc_m = '0;
  logic [15:0] rxcrc_m = '0;

  parse_res_t  pending_res_q [$];
  typed_ev_t   typed_q [$];
  int unsigned err_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ev_cnt [8];
  bit          no_idle = 1'b0;
  bit          stall_req = 1'b0;

  dir_row_t dir_tab [26] = '{
    '{8'h55, 1'b1, fpr_pkg::EvNone},
    '{fpr_pkg::ByteStx, 1'b0, fpr_pkg::EvNone}, '{8'h00, 1'b0, fpr_pkg::EvNone},
    '{8'h00, 1'b0, fpr_pkg::EvNone}, '{8'h01, 1'b0, fpr_pkg::EvNone},
    '{8'h00, 1'b1, fpr_pkg::EvBadLen},
    '{fpr_pkg::ByteStx, 1'b0, fpr_pkg::EvNone}, '{8'hff, 1'b0, fpr_pkg::EvNone},
    '{8'hff, 1'b0, fpr_pkg::EvNone}, '{8'h03, 1'b0, fpr_pkg::EvNone},
    '{8'h04, 1'b1, fpr_pkg::EvBadLen},
    '{fpr_pkg::ByteStx, 1'b0, fpr_pkg::EvNone}, '{8'h34, 1'b0, fpr_pkg::EvNone},
    '{8'h12, 1'b0, fpr_pkg::EvNone}, '{8'h02, 1'b0, fpr_pkg::EvNone},
    '{8'h00, 1'b0, fpr_pkg::EvNone}, '{8'h00, 1'b0, fpr_pkg::EvNone},
    '{KindCmd, 1'b0, fpr_pkg::EvNone}, '{8'hff, 1'b0, fpr_pkg::EvNone},
    '{8'hff, 1'b0, fpr_pkg::EvNone}, '{8'h00, 1'b0, fpr_pkg::EvNone},
    '{8'h00, 1'b0, fpr_pkg::EvNone}, '{8'hff, 1'b1, fpr_pkg::EvBadEtx},
    '{fpr_pkg::ByteStx, 1'b0, fpr_pkg::EvNone}, '{8'h00, 1'b0, fpr_pkg::EvNone},
    '{8'hff, 1'b0, fpr_pkg::EvNone}
  };

  framed_packet_rx_parser DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_res_o      (event_res_o),
    .payload_byte_o   (payload_byte_o),
    .payload_index_o  (payload_index_o),
    .frame_version_o  (frame_version_o),
    .transaction_id_o (transaction_id_o),
    .frame_kind_o     (frame_kind_o),
    .command_code_o   (command_code_o),
    .payload_length_o (payload_length_o),
    .crc_ok_o         (crc_ok_o),
    .computed_crc_o   (computed_crc_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [15:0] kermit_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
    return c;
  endfunction

  function automatic parse_res_t parse_byte(input logic [7:0] b);
    parse_res_t r;
    r = '0;
    r.ev = fpr_pkg::EvNone;
    case (ps)
      PsHunt: if (b == fpr_pkg::ByteStx) ps = PsVerLo;
      PsVerLo: begin
        ver_m = {8'h00, b};
        ps = PsVerHi;
      end
      PsVerHi: begin
        ver_m[15:8] = b;
        crc_m = '0;
        ps = PsLenLo;
      end
      PsLenLo: begin
        len_m = {8'h00, b};
        crc_m = kermit_update(crc_m, b);
        ps = PsLenHi;
      end
      PsLenHi: begin
        len_m[15:8] = b;
        if (len_m >= 16'd2 && int'(len_m) <= MaxLen) begin
          crc_m = kermit_update(crc_m, b);
          len_m = len_m - 16'd2;
          ps = PsTid;
        end else begin
          r.ev = fpr_pkg::EvBadLen;
          ps = PsHunt;
        end
      end
      PsTid: begin
        tid_m = b;
        ps = PsKind;
      end
      PsKind: begin
        kind_m = b;
        crc_m = kermit_update(crc_m, b);
        ps = PsCmdLo;
      end
      PsCmdLo: begin
        cmd_m = {8'h00, b};
        crc_m = kermit_update(crc_m, b);
        ps = PsCmdHi;
      end
      PsCmdHi: begin
        cmd_m[15:8] = b;
        crc_m = kermit_update(crc_m, b);
        cnt_m = '0;
        ps = (len_m != 16'd0) ? PsPayload : PsCrcLo;
      end
      PsPayload: begin
        r.ev = fpr_pkg::EvPayload;
        r.pbyte = b;
        r.pidx = cnt_m[9:0];
        crc_m = kermit_update(crc_m, b);
        cnt_m = cnt_m + 16'd1;
        if (cnt_m >= len_m) ps = PsCrcLo;
      end
      PsCrcLo: begin
        rxcrc_m = {8'h00, b};
        ps = PsCrcHi;
      end
      PsCrcHi: begin
        rxcrc_m[15:8] = b;
        if (enforce_m && rxcrc_m != crc_m) begin
          r.ev = fpr_pkg::EvBadCrc;
          ps = PsHunt;
        end else begin
          ps = PsEtx;
        end
      end
      PsEtx: begin
        r.ev = (b == fpr_pkg::ByteEtx) ? fpr_pkg::EvDone : fpr_pkg::EvBadEtx;
        ps = PsHunt;
      end
      default: ps = PsHunt;
    endcase
    r.ver = ver_m;
    r.tid = tid_m;
    r.kind = kind_m;
    r.cmd = cmd_m;
    r.plen = len_m[10:0];
    r.crc_ok = (rxcrc_m == crc_m);
    r.crc = crc_m;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    parse_res_t want;
    typed_ev_t  tev;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_res_q.size() == 0) begin
          $display("%0t: result with no expected item, expected none, actual event %0d",
                   $time, event_res_o);
          err_cnt++;
        end else begin
          want = pending_res_q.pop_front();
          check_field("event_res", want.ev, event_res_o);
          check_field("payload_byte", want.pbyte, payload_byte_o);
          check_field("payload_index", want.pidx, payload_index_o);
          check_field("frame_version", want.ver, frame_version_o);
          check_field("transaction_id", want.tid, transaction_id_o);
          check_field("frame_kind", want.kind, frame_kind_o);
          check_field("command_code", want.cmd, command_code_o);
          check_field("payload_length", want.plen, payload_length_o);
          check_field("crc_ok", want.crc_ok, crc_ok_o);
          check_field("computed_crc", want.crc, computed_crc_o);
          ev_cnt[event_res_o]++;
          res_cnt++;
        end
      end
      if (cfg_valid_i && cfg_ready_o) enforce_m = cfg_data_i;
      if (in_valid_i && in_ready_o) begin
        tev = typed_q.pop_front();
        want = parse_byte(rx_byte_i);
        if (tev.typed) want.ev = tev.ev;
        pending_res_q.push_back(want);
      end
    end
  end

  initial begin : sink
    int unsigned r;
    int unsigned n;
    wait (rst_ni);
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
      end else if (no_idle) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready_i <= 1'b1;
          n = $urandom_range(1, 12);
        end else if (r < 93) begin
          out_ready_i <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          n = $urandom_range(8, 30);
        end
        repeat (n) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic typed, input fpr_pkg::rx_event_e ev);
    typed_ev_t   tev;
    int unsigned gap;
    bit          ok;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tev.typed = typed;
    tev.ev = ev;
    typed_q.push_back(tev);
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do begin
      @(negedge clk_i);
      ok = in_ready_o;
      @(posedge clk_i);
    end while (!ok);
    sent_cnt++;
  endtask

  task automatic write_enforce(input logic v);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do begin
      @(negedge clk_i);
      ok = cfg_ready_o;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_res_q.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_frame(input bit max_len);
    logic [7:0]  fb [$];
    logic [7:0]  b;
    logic [7:0]  kind;
    logic [15:0] len_f;
    logic [15:0] ver;
    logic [15:0] cmd;
    logic [15:0] crc;
    int unsigned mode;
    int unsigned r;
    int unsigned n_pay;
    int unsigned n;
    mode = max_len ? 0 : $urandom_range(0, 99);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        b = 8'($urandom);
        if (b == fpr_pkg::ByteStx && $urandom_range(0, 3) != 0) b = 8'ha5;
        fb.push_back(b);
      end
    end
    r = $urandom_range(0, 99);
    if (max_len) n_pay = MaxLen - 2;
    else if (r < 75) n_pay = $urandom_range(0, 8);
    else if (r < 95) n_pay = $urandom_range(9, 40);
    else n_pay = $urandom_range(41, 200);
    len_f = 16'(n_pay + 2);
    if (mode >= 82 && mode < 91) begin
      case ($urandom_range(0, 4))
        0: len_f = 16'd0;
        1: len_f = 16'd1;
        2: len_f = 16'(MaxLen + 1);
        3: len_f = 16'hffff;
        default: len_f = 16'($urandom_range(MaxLen + 1, 65535));
      endcase
    end
    ver = 16'($urandom);
    cmd = 16'($urandom);
    r = $urandom_range(0, 99);
    kind = (r < 45) ? KindCmd : (r < 90) ? KindStatus : 8'($urandom);
    fb.push_back(fpr_pkg::ByteStx);
    fb.push_back(ver[7:0]);
    fb.push_back(ver[15:8]);
    fb.push_back(len_f[7:0]);
    fb.push_back(len_f[15:8]);
    if (!(mode >= 82 && mode < 91)) begin
      crc = kermit_update(16'h0000, len_f[7:0]);
      crc = kermit_update(crc, len_f[15:8]);
      fb.push_back(8'($urandom));
      fb.push_back(kind);
      crc = kermit_update(crc, kind);
      fb.push_back(cmd[7:0]);
      crc = kermit_update(crc, cmd[7:0]);
      fb.push_back(cmd[15:8]);
      crc = kermit_update(crc, cmd[15:8]);
      repeat (n_pay) begin
        b = 8'($urandom);
        fb.push_back(b);
        crc = kermit_update(crc, b);
      end
      if (mode >= 60 && mode < 74) crc = crc ^ (16'd1 << $urandom_range(0, 15));
      fb.push_back(crc[7:0]);
      fb.push_back(crc[15:8]);
      if (mode >= 74 && mode < 82) begin
        b = 8'($urandom);
        if (b == fpr_pkg::ByteEtx) b = 8'hff;
        fb.push_back(b);
      end else begin
        fb.push_back(fpr_pkg::ByteEtx);
      end
      if (mode >= 91) begin
        n = $urandom_range(1, 6);
        repeat (n) if (fb.size() > 1) void'(fb.pop_back());
      end
    end
    foreach (fb[i]) send_byte(fb[i], 1'b0, fpr_pkg::EvNone);
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].ev);
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_enforce((ph % 2) == 1);
      no_idle = (ph == 2);
      phase_end = sent_cnt + PhaseItems;
      if (ph == 1) stall_req = 1'b1;
      if (ph == 2) send_frame(1'b1);
      while (sent_cnt < phase_end) send_frame(1'b0);
    end
    settle();
    $display("Summary: %0d items sent, %0d results checked, %0d payload bytes, %0d complete.",
             sent_cnt, res_cnt, ev_cnt[fpr_pkg::EvPayload], ev_cnt[fpr_pkg::EvDone]);
    $display("Summary: %0d bad length, %0d bad ETX, %0d bad CRC, CRC enforce clear and set.",
             ev_cnt[fpr_pkg::EvBadLen], ev_cnt[fpr_pkg::EvBadEtx], ev_cnt[fpr_pkg::EvBadCrc]);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fpr_pkg.sv
hw/rtl/framed_packet_rx_parser.sv
sim/tb_top.sv
